### sv/distance_to_color_map_top_assert.svh
// Assertion macros for the distance to color map block.
`ifndef DISTANCE_TO_COLOR_MAP_TOP_ASSERT_SVH
`define DISTANCE_TO_COLOR_MAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DTCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtcm assertion failed");
`define DTCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtcm assertion failed");
`else
`define DTCM_ASSERT_IMP(lbl, ante, cons)
`define DTCM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/dtcm_pkg.sv
package dtcm_pkg;

  localparam int COLOR_BITS = 8;
  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 23;
  localparam int DIFF_W     = 25;
  localparam int SQ_W       = 50;
  localparam int SUM_W      = 51;
  localparam int SQRT_IN_W  = 52;
  localparam int ROOT_W     = 26;
  localparam int REM_W      = 28;
  localparam int FRAC_W     = 16;
  localparam int T_W        = 19;
  localparam int LEVEL_W    = 16;
  localparam int CFG_ADDR_W = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_REF_X  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_Y  = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_Z  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 8'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd4096;

  // Ramp breakpoints on t = 5 * fraction.
  localparam logic [T_W-1:0] T_SEG1 = 19'd32768;
  localparam logic [T_W-1:0] T_SEG2 = 19'd49152;
  localparam logic [T_W-1:0] T_SEG3 = 19'd65536;
  localparam logic [T_W-1:0] T_END  = 19'd98304;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = {COLOR_BITS{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] atom_x;
    logic signed [COORD_W-1:0] atom_y;
    logic signed [COORD_W-1:0] atom_z;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  radius_zero;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic radius_zero;
  } ctl_t;

endpackage

### sv/dtcm_dist.sv
module dtcm_dist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  dtcm_pkg::ctl_t                        ctl_in,
  input  dtcm_pkg::in_word_t                    pt,
  input  logic signed [dtcm_pkg::COORD_W-1:0]   ref_x,
  input  logic signed [dtcm_pkg::COORD_W-1:0]   ref_y,
  input  logic signed [dtcm_pkg::COORD_W-1:0]   ref_z,
  output dtcm_pkg::ctl_t                        ctl_out,
  output logic [dtcm_pkg::SUM_W-1:0]            sum
);

  dtcm_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic [dtcm_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [dtcm_pkg::DIFF_W-1:0] mx_nxt, my_nxt, mz_nxt;
  logic [dtcm_pkg::DIFF_W-1:0] mx_r, my_r, mz_r;
  logic [dtcm_pkg::SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [dtcm_pkg::SUM_W-1:0]  sum_r, sum_nxt;

  always_comb begin
    dx = {pt.atom_x[dtcm_pkg::COORD_W-1], pt.atom_x} - {ref_x[dtcm_pkg::COORD_W-1], ref_x};
    dy = {pt.atom_y[dtcm_pkg::COORD_W-1], pt.atom_y} - {ref_y[dtcm_pkg::COORD_W-1], ref_y};
    dz = {pt.atom_z[dtcm_pkg::COORD_W-1], pt.atom_z} - {ref_z[dtcm_pkg::COORD_W-1], ref_z};
    // The magnitude stays below 2^24, which still fits unsigned.
    mx_nxt = dx[dtcm_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
    my_nxt = dy[dtcm_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
    mz_nxt = dz[dtcm_pkg::DIFF_W-1] ? (~dz + 1'b1) : dz;
    sum_nxt = {1'b0, sx_r} + {1'b0, sy_r} + {1'b0, sz_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      mz_r  <= mz_nxt;
      sx_r  <= mx_r * mx_r;
      sy_r  <= my_r * my_r;
      sz_r  <= mz_r * mz_r;
      sum_r <= sum_nxt;
    end
  end

  assign ctl_out = ctl3_r;
  assign sum     = sum_r;

endmodule

### sv/dtcm_sqrt.sv
module dtcm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  dtcm_pkg::ctl_t                ctl_in,
  input  logic [dtcm_pkg::SUM_W-1:0]    radicand,
  output dtcm_pkg::ctl_t                ctl_out,
  output logic [dtcm_pkg::ROOT_W-1:0]   root
);

  localparam int N = dtcm_pkg::ROOT_W;

  logic [dtcm_pkg::SQRT_IN_W-1:0] rad_r  [N];
  logic [dtcm_pkg::REM_W-1:0]     rem_r  [N];
  logic [dtcm_pkg::ROOT_W-1:0]    root_r [N];
  dtcm_pkg::ctl_t                 ctl_r  [N];

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [dtcm_pkg::SQRT_IN_W-1:0] rad_in;
    logic [dtcm_pkg::REM_W-1:0]     rem_in, rem_sh, trial, rem_nxt;
    logic [dtcm_pkg::ROOT_W-1:0]    root_in, root_nxt;
    dtcm_pkg::ctl_t                 ctl_stg;
    logic                           ge;

    if (k == 0) begin : g_first
      assign rad_in  = {1'b0, radicand};
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctl_stg = ctl_in;
    end else begin : g_next
      assign rad_in  = {rad_r[k-1][dtcm_pkg::SQRT_IN_W-3:0], 2'b00};
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign ctl_stg = ctl_r[k-1];
    end

    always_comb begin
      rem_sh   = {rem_in[dtcm_pkg::REM_W-3:0], rad_in[dtcm_pkg::SQRT_IN_W-1 -: 2]};
      trial    = {root_in, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[dtcm_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_stg;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign ctl_out = ctl_r[N-1];
  assign root    = root_r[N-1];

endmodule

### sv/dtcm_div.sv
module dtcm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  dtcm_pkg::ctl_t                 ctl_in,
  input  logic [dtcm_pkg::ROOT_W-1:0]    dist_in,
  input  logic [dtcm_pkg::RADIUS_W-1:0]  radius,
  output dtcm_pkg::ctl_t                 ctl_out,
  output logic [dtcm_pkg::FRAC_W-1:0]    frac
);

  localparam int N   = dtcm_pkg::FRAC_W;
  localparam int RW  = dtcm_pkg::RADIUS_W + 1;

  // Head stage: the quotient of dist_in * 2^13 / radius overflows 16 bits
  // exactly when dist_in >= 8 * radius.
  dtcm_pkg::ctl_t ctl0_r;
  logic           sat0_r;
  logic [RW-1:0]  rem0_r;
  logic [2:0]     low0_r;

  logic [RW-1:0]  rem_r [N];
  logic [N-1:0]   q_r   [N];
  logic           sat_r [N];
  logic [2:0]     low_r [N];
  dtcm_pkg::ctl_t ctl_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat0_r <= (dist_in >= {radius, 3'b000});
      rem0_r <= {1'b0, dist_in[dtcm_pkg::ROOT_W-1:3]};
      low0_r <= dist_in[2:0];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [RW-1:0]  rem_in, rem_sh, rem_nxt;
    logic [N-1:0]   q_in;
    logic           sat_in, low_bit, ge;
    logic [2:0]     low_in;
    dtcm_pkg::ctl_t ctl_stg;

    if (j == 0) begin : g_first
      assign rem_in  = rem0_r;
      assign q_in    = '0;
      assign sat_in  = sat0_r;
      assign low_in  = low0_r;
      assign ctl_stg = ctl0_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign sat_in  = sat_r[j-1];
      assign low_in  = low_r[j-1];
      assign ctl_stg = ctl_r[j-1];
    end

    // The first bits shifted into the remainder are dist_in's low three bits, the rest are zero.
    if (j < 3) begin : g_dbit
      assign low_bit = low_in[2-j];
    end else begin : g_zbit
      assign low_bit = 1'b0;
    end

    always_comb begin
      rem_sh  = {rem_in[RW-2:0], low_bit};
      ge      = (rem_sh >= {1'b0, radius});
      rem_nxt = ge ? (rem_sh - {1'b0, radius}) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else if (en) begin
        ctl_r[j] <= ctl_stg;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= {q_in[N-2:0], ge};
        sat_r[j] <= sat_in;
        low_r[j] <= low_in;
      end
    end
  end

  assign ctl_out = ctl_r[N-1];
  assign frac    = sat_r[N-1] ? {N{1'b1}} : q_r[N-1];

endmodule

### sv/dtcm_ramp.sv
module dtcm_ramp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  dtcm_pkg::ctl_t                ctl_in,
  input  logic [dtcm_pkg::FRAC_W-1:0]   frac,
  output logic                          out_valid,
  output dtcm_pkg::out_word_t           out_word
);

  localparam int LW = dtcm_pkg::LEVEL_W;
  localparam int PW = dtcm_pkg::LEVEL_W + dtcm_pkg::COLOR_BITS;
  localparam logic [PW-1:0] ROUND_HALF = PW'(16384);

  logic [dtcm_pkg::T_W-1:0] t, d2, d3, d3b, d4, d4b;
  logic [LW-1:0] r_nxt, g_nxt, b_nxt;
  logic [LW-1:0] r_r, g_r, b_r;
  dtcm_pkg::ctl_t ctl_a_r;

  logic [PW-1:0] rp, gp, bp;
  logic          out_valid_r;
  dtcm_pkg::out_word_t out_word_r, out_word_nxt;

  // Levels are on a scale where 32768 means full intensity.
  always_comb begin
    t   = {3'b000, frac} + {1'b0, frac, 2'b00};
    d2  = dtcm_pkg::T_SEG2 - t;
    d3  = dtcm_pkg::T_SEG3 - t;
    d3b = t - dtcm_pkg::T_SEG2;
    d4  = t - dtcm_pkg::T_SEG3;
    d4b = dtcm_pkg::T_END - t;
    r_nxt = '0;
    g_nxt = '0;
    b_nxt = '0;
    priority if (t < dtcm_pkg::T_SEG1) begin
      r_nxt = dtcm_pkg::LEVEL_ONE;
      g_nxt = t[LW-1:0];
    end else if (t < dtcm_pkg::T_SEG2) begin
      r_nxt = {d2[LW-2:0], 1'b0};
      g_nxt = dtcm_pkg::LEVEL_ONE;
    end else if (t < dtcm_pkg::T_SEG3) begin
      g_nxt = {d3[LW-2:0], 1'b0};
      b_nxt = {d3b[LW-2:0], 1'b0};
    end else begin
      r_nxt = (d4 > {3'b000, dtcm_pkg::LEVEL_ONE}) ? dtcm_pkg::LEVEL_ONE : d4[LW-1:0];
      b_nxt = (t >= dtcm_pkg::T_END) ? '0 : d4b[LW-1:0];
    end
  end

  always_comb begin
    rp = PW'(r_r) * PW'(dtcm_pkg::COLOR_MAX) + ROUND_HALF;
    gp = PW'(g_r) * PW'(dtcm_pkg::COLOR_MAX) + ROUND_HALF;
    bp = PW'(b_r) * PW'(dtcm_pkg::COLOR_MAX) + ROUND_HALF;
    out_word_nxt.radius_zero = ctl_a_r.radius_zero;
    if (ctl_a_r.radius_zero) begin
      out_word_nxt.red   = '0;
      out_word_nxt.green = '0;
      out_word_nxt.blue  = '0;
    end else begin
      out_word_nxt.red   = rp[15 +: dtcm_pkg::COLOR_BITS];
      out_word_nxt.green = gp[15 +: dtcm_pkg::COLOR_BITS];
      out_word_nxt.blue  = bp[15 +: dtcm_pkg::COLOR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_a_r     <= ctl_in;
      out_valid_r <= ctl_a_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r        <= r_nxt;
      g_r        <= g_nxt;
      b_r        <= b_nxt;
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### sv/distance_to_color_map_top.sv
// Throughput: one word per cycle unless the output is stalled; the square root
// (26 stages, one root bit each) and the divider (one quotient bit per stage after a
// head stage) are fully pipelined. A stalled output word freezes every stage, so
// nothing is lost or repeated. Reset (synchronous, rst_n low) empties the pipeline,
// clears the reference point to zero and sets the radius to RADIUS_RESET (4096).
`include "distance_to_color_map_top_assert.svh"

module distance_to_color_map_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dtcm_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dtcm_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dtcm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [dtcm_pkg::COORD_W-1:0]         cfg_wdata
);

  logic signed [dtcm_pkg::COORD_W-1:0] ref_x_r, ref_y_r, ref_z_r;
  logic [dtcm_pkg::RADIUS_W-1:0]       radius_r;

  logic                              en;
  dtcm_pkg::ctl_t                    ctl_in, ctl_dist, ctl_sqrt, ctl_div;
  logic [dtcm_pkg::SUM_W-1:0]        sum;
  logic [dtcm_pkg::ROOT_W-1:0]       dist_val;
  logic [dtcm_pkg::FRAC_W-1:0]       frac;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r  <= '0;
      ref_y_r  <= '0;
      ref_z_r  <= '0;
      radius_r <= dtcm_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        dtcm_pkg::CFG_REF_X:  ref_x_r  <= cfg_wdata;
        dtcm_pkg::CFG_REF_Y:  ref_y_r  <= cfg_wdata;
        dtcm_pkg::CFG_REF_Z:  ref_z_r  <= cfg_wdata;
        dtcm_pkg::CFG_RADIUS: radius_r <= cfg_wdata[dtcm_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the output word is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign ctl_in.valid       = in_valid;
  assign ctl_in.radius_zero = (radius_r == '0);

  dtcm_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl_in),
    .pt      (in_data),
    .ref_x   (ref_x_r),
    .ref_y   (ref_y_r),
    .ref_z   (ref_z_r),
    .ctl_out (ctl_dist),
    .sum     (sum)
  );

  dtcm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (ctl_dist),
    .radicand (sum),
    .ctl_out  (ctl_sqrt),
    .root     (dist_val)
  );

  dtcm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl_sqrt),
    .dist_in (dist_val),
    .radius  (radius_r),
    .ctl_out (ctl_div),
    .frac    (frac)
  );

  dtcm_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (ctl_div),
    .frac      (frac),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

  `DTCM_ASSERT_IMP(a_zero_radius_black, out_valid && out_data.radius_zero, out_data.red == '0 && out_data.green == '0 && out_data.blue == '0)
  `DTCM_ASSERT_IMP(a_one_channel_off, out_valid, out_data.red == '0 || out_data.green == '0 || out_data.blue == '0)
  `DTCM_ASSERT_NXT(a_radius_write, cfg_valid && cfg_ready && cfg_addr == dtcm_pkg::CFG_RADIUS, radius_r == $past(cfg_wdata[dtcm_pkg::RADIUS_W-1:0]))

endmodule
